/* hw/rtl/vtec_pkg.sv */
// ----------------------------------------------------------------------------
// vtec_pkg
// Shared types and constants of the VT100 escape cursor engine.
// ----------------------------------------------------------------------------
package vtec_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 128;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [6:0]  MAX_ROWS_RST = 7'd16;
  localparam logic [7:0]  MAX_COLS_RST = 8'd21;
  localparam logic [15:0] FG_RST       = 16'hFFFF;
  localparam logic [15:0] BG_RST       = 16'h0000;

  localparam logic [1:0] REG_MAX_ROWS = 2'd0;
  localparam logic [1:0] REG_MAX_COLS = 2'd1;

  localparam logic [7:0] CH_ESC   = 8'd27;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] CMD_DRAW  = 2'd0;
  localparam logic [1:0] CMD_ERASE = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [2:0] OP_DRAW  = 3'd0;
  localparam logic [2:0] OP_CR    = 3'd1;
  localparam logic [2:0] OP_LF    = 3'd2;
  localparam logic [2:0] OP_BS    = 3'd3;
  localparam logic [2:0] OP_FINAL = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
    logic       st;
    logic [7:0] p1;
    logic [7:0] p2;
    logic       h1;
    logic       h2;
  } op_t;

  function automatic logic [15:0] color_lut(input logic [2:0] idx);
    logic [15:0] c;
    case (idx)
      3'd0: c = 16'h0000;
      3'd1: c = 16'hF800;
      3'd2: c = 16'h07E0;
      3'd3: c = 16'hFFE0;
      3'd4: c = 16'h001F;
      3'd5: c = 16'hF81F;
      3'd6: c = 16'h07FF;
      default: c = 16'hFFFF;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/vtec_front.sv */
// ----------------------------------------------------------------------------
// vtec_front
// Escape phase tracking and parameter gathering; issues ops to the queue.
// ----------------------------------------------------------------------------
module vtec_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [7:0]       ch,
  input  logic             st,
  output logic             push,
  output vtec_pkg::op_t    op
);
  import vtec_pkg::*;

  localparam logic [1:0] PH_PLAIN = 2'd0;
  localparam logic [1:0] PH_ESC   = 2'd1;
  localparam logic [1:0] PH_CSI   = 2'd2;

  logic [1:0] phase, phase_next;
  logic [1:0] slot, slot_next;
  logic [7:0] p1, p1_next, p2, p2_next;
  logic       h1, h1_next, h2, h2_next;
  logic [11:0] acc;
  logic [7:0]  acc_in;
  logic        is_digit;

  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign acc_in   = (slot == 2'd0) ? p1 : p2;
  assign acc      = 12'(acc_in) * 12'd10 + 12'(ch - CH_ZERO);

  always_comb begin
    phase_next = phase;
    slot_next  = slot;
    p1_next    = p1;
    p2_next    = p2;
    h1_next    = h1;
    h2_next    = h2;
    push       = 1'b0;
    op.ch      = ch;
    op.st      = st;
    op.p1      = p1;
    op.p2      = p2;
    op.h1      = h1;
    op.h2      = h2;
    op.kind    = OP_DRAW;
    case (phase)
      PH_CSI: begin
        if (is_digit) begin
          if (slot == 2'd0) begin
            p1_next = (acc > 12'd255) ? 8'd255 : acc[7:0];
            h1_next = 1'b1;
          end else if (slot == 2'd1) begin
            p2_next = (acc > 12'd255) ? 8'd255 : acc[7:0];
            h2_next = 1'b1;
          end
        end else if (ch == CH_SEMI) begin
          if (slot < 2'd2) slot_next = slot + 2'd1;
        end else begin
          phase_next = PH_PLAIN;
          push       = in_valid;
          op.kind    = OP_FINAL;
          slot_next  = 2'd0;
          p1_next    = 8'd0;
          p2_next    = 8'd0;
          h1_next    = 1'b0;
          h2_next    = 1'b0;
        end
      end
      PH_ESC: begin
        phase_next = (ch == CH_LBRK) ? PH_CSI : PH_PLAIN;
        slot_next  = 2'd0;
        p1_next    = 8'd0;
        p2_next    = 8'd0;
        h1_next    = 1'b0;
        h2_next    = 1'b0;
      end
      default: begin
        if (ch == CH_ESC) begin
          phase_next = PH_ESC;
        end else begin
          push = in_valid;
          if (ch == CH_CR) op.kind = OP_CR;
          else if (ch == CH_LF) op.kind = OP_LF;
          else if (ch == CH_BS) op.kind = OP_BS;
          else op.kind = OP_DRAW;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_PLAIN;
      slot  <= 2'd0;
      p1    <= 8'd0;
      p2    <= 8'd0;
      h1    <= 1'b0;
      h2    <= 1'b0;
    end else if (in_valid) begin
      phase <= phase_next;
      slot  <= slot_next;
      p1    <= p1_next;
      p2    <= p2_next;
      h1    <= h1_next;
      h2    <= h2_next;
    end
  end

endmodule

/* hw/rtl/vtec_queue.sv */
// ----------------------------------------------------------------------------
// vtec_queue
// Small FIFO of ops between the front and back parts.
// ----------------------------------------------------------------------------
module vtec_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  vtec_pkg::op_t wr_op,
  input  logic          pop,
  output vtec_pkg::op_t rd_op,
  output logic          not_empty,
  output logic          full
);
  import vtec_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  op_t         mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  assign not_empty = (count != '0);
  assign full      = (count == (AW+1)'(QUEUE_DEPTH));
  assign rd_op     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

/* hw/rtl/vtec_back.sv */
// ----------------------------------------------------------------------------
// vtec_back
// Executes ops: cursor, saved cursor, wrap, colors; registers the commands.
// ----------------------------------------------------------------------------
module vtec_back (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    rows,
  input  logic [7:0]    cols,
  input  vtec_pkg::op_t op,
  input  logic          op_valid,
  output logic          pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [63:0]   m_tdata,
  output logic          m_tuser
);
  import vtec_pkg::*;

  logic [7:0]  crow, ccol, srow, scol, row_c, col_c;
  logic [7:0]  row_n, col_n, srow_n, scol_n, n;
  logic [8:0]  row_add, col_add;
  logic        wrap, wrap_n;
  logic [15:0] fg, bg, fg_n, bg_n;
  logic        emit;
  logic [1:0]  e_cmd;
  logic [7:0]  e_row, e_cs, e_ce, e_gl;
  logic        c1_ok;

  assign pop   = op_valid && (!m_tvalid || m_tready);
  assign row_c = (crow >= rows) ? rows - 8'd1 : crow;
  assign col_c = (ccol >= cols) ? cols - 8'd1 : ccol;
  assign n     = op.h1 ? op.p1 : 8'd1;
  assign row_add = {1'b0, row_c} + {1'b0, n};
  assign col_add = {1'b0, col_c} + {1'b0, n};
  assign c1_ok = op.h1 && (op.p1 >= 8'd30) && (op.p1 <= 8'd47);

  always_comb begin
    row_n  = row_c;
    col_n  = col_c;
    srow_n = srow;
    scol_n = scol;
    wrap_n = wrap;
    fg_n   = fg;
    bg_n   = bg;
    emit   = 1'b0;
    e_cmd  = CMD_DRAW;
    e_row  = row_c;
    e_cs   = col_c;
    e_ce   = cols;
    e_gl   = CH_SPACE;
    case (op.kind)
      OP_CR: col_n = 8'd0;
      OP_LF: if ({1'b0, row_c} + 9'd1 < {1'b0, rows}) row_n = row_c + 8'd1;
      OP_BS: if (col_c != 8'd0) col_n = col_c - 8'd1;
      OP_FINAL: begin
        case (op.ch)
          "h": if (op.h1 && op.p1 == 8'd7) wrap_n = 1'b1;
          "l": if (op.h1 && op.p1 == 8'd7) wrap_n = 1'b0;
          "H", "f": begin
            if (op.h1 && op.p1 < rows) row_n = op.p1;
            if (op.h2 && op.p2 < cols) col_n = op.p2;
            if (!op.h1 && !op.h2) begin
              row_n = 8'd0;
              col_n = 8'd0;
            end
          end
          "A": row_n = (n > row_c) ? 8'd0 : row_c - n;
          "B": row_n = (row_add >= {1'b0, rows}) ? rows - 8'd1 : row_add[7:0];
          "C": col_n = (col_add >= {1'b0, cols}) ? cols - 8'd1 : col_add[7:0];
          "D": col_n = (n > col_c) ? 8'd0 : col_c - n;
          "s": begin
            srow_n = row_c;
            scol_n = col_c;
          end
          "u": begin
            row_n = (srow >= rows) ? rows - 8'd1 : srow;
            col_n = (scol >= cols) ? cols - 8'd1 : scol;
          end
          "K": begin
            emit  = 1'b1;
            e_cmd = CMD_ERASE;
            if (op.h1 && op.p1 == 8'd1) begin
              e_cs = 8'd0;
              e_ce = col_c;
            end else if (op.h1 && op.p1 == 8'd2) begin
              e_cs = 8'd0;
            end
          end
          "J": if (op.h1 && op.p1 == 8'd2) begin
            emit  = 1'b1;
            e_cmd = CMD_CLEAR;
            e_row = 8'd0;
            e_cs  = 8'd0;
            e_ce  = 8'd0;
            row_n = 8'd0;
            col_n = 8'd0;
          end
          "m": if (c1_ok) begin
            if (op.p1 <= 8'd37) fg_n = color_lut(op.p1[2:0] - 3'd6);
            else if (op.p1 >= 8'd40) bg_n = color_lut(op.p1[2:0]);
            if (op.h2 && op.p2 >= 8'd30 && op.p2 <= 8'd37)
              fg_n = color_lut(op.p2[2:0] - 3'd6);
            else if (op.h2 && op.p2 >= 8'd40 && op.p2 <= 8'd47)
              bg_n = color_lut(op.p2[2:0]);
          end
          default: ;
        endcase
      end
      default: begin
        emit  = 1'b1;
        e_ce  = col_c + 8'd1;
        e_gl  = op.ch;
        if ({1'b0, col_c} + 9'd1 >= {1'b0, cols}) begin
          if (wrap) begin
            col_n = 8'd0;
            if ({1'b0, row_c} + 9'd1 < {1'b0, rows}) row_n = row_c + 8'd1;
          end
        end else begin
          col_n = col_c + 8'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crow     <= 8'd0;
      ccol     <= 8'd0;
      srow     <= 8'd0;
      scol     <= 8'd0;
      wrap     <= 1'b0;
      fg       <= FG_RST;
      bg       <= BG_RST;
      m_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        crow <= row_n;
        ccol <= col_n;
        srow <= srow_n;
        scol <= scol_n;
        wrap <= wrap_n;
        fg   <= fg_n;
        bg   <= bg_n;
      end
      if (pop && emit) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      m_tdata <= {bg, fg, e_gl, e_ce, e_cs, e_row[5:0], e_cmd};
      m_tuser <= op.st;
    end
  end

endmodule

/* hw/rtl/vt100_escape_cursor_engine.sv */
// ----------------------------------------------------------------------------
// vt100_escape_cursor_engine
// Character stream to draw / erase / clear commands with VT100 escapes.
// ----------------------------------------------------------------------------
// Input stream s_*: one byte per beat, tdata = char_code, tuser = see_through.
// Output stream m_*: one beat per drawn byte (not ESC/CR/LF/BS), K sequence or 2J.
//   tdata = command, row, col_start, col_end, glyph, fg_color, bg_color;
//   tuser = see_through_out.
// Config port: cfg_we / cfg_index / cfg_wdata, index 0 max_rows, 1 max_cols;
//   indexes 2 and 3 are not stored; write only while idle.
// Throughput: the front parser takes one byte per cycle while the op queue has
// room; the back unit retires one op per cycle while the output is not stalled.
// With the queue empty, an accepted byte is written into the op queue and its
// command beat is registered on the output when the back unit retires the op.
// A stalled output holds its beat; the back unit stops, the queue
// fills, and s_tready drops once four ops are waiting.
// Reset clears the parser, the cursor, wrap and queue, loads default colors.
// ----------------------------------------------------------------------------
module vt100_escape_cursor_engine #(
  parameter int MAX_ROWS = vtec_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = vtec_pkg::MAX_COLS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_code
  input  logic        s_tuser,   // see_through
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // command, row, col_start, col_end, glyph, fg, bg
  output logic        m_tuser,   // see_through_out
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import vtec_pkg::*;

  localparam logic [7:0] ROWS_LIM = 8'(MAX_ROWS);
  localparam logic [7:0] COLS_LIM = 8'(MAX_COLS);

  logic [6:0] max_rows;
  logic [7:0] max_cols;
  logic [7:0] rows, cols;
  logic       push, pop, q_ne, q_full;
  op_t        f_op, q_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_rows <= MAX_ROWS_RST;
      max_cols <= MAX_COLS_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_MAX_ROWS) max_rows <= cfg_wdata[6:0];
      if (cfg_index == REG_MAX_COLS) max_cols <= cfg_wdata[7:0];
    end
  end

  assign rows = (max_rows == 7'd0) ? 8'd1 :
                ({1'b0, max_rows} > ROWS_LIM) ? ROWS_LIM : {1'b0, max_rows};
  assign cols = (max_cols == 8'd0) ? 8'd1 : (max_cols > COLS_LIM) ? COLS_LIM : max_cols;

  assign s_tready = !q_full;

  vtec_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_tvalid && s_tready),
    .ch(s_tdata), .st(s_tuser), .push(push), .op(f_op)
  );

  vtec_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wr_op(f_op), .pop(pop),
    .rd_op(q_op), .not_empty(q_ne), .full(q_full)
  );

  vtec_back u_back (
    .clk(clk), .rst(rst), .rows(rows), .cols(cols), .op(q_op), .op_valid(q_ne),
    .pop(pop), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat lost under stall");
  a_cmd_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3)
    else $error("illegal command code");
  a_no_pop_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !pop)
    else $error("op retired while output stalled");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("push into full queue");
`endif

endmodule

/* tb/vt100_escape_cursor_engine_tb.sv */
// ----------------------------------------------------------------------------
// vt100_escape_cursor_engine_tb
// Streams text and escape sequences into the cursor engine, predicts each
// draw / erase / clear command, and compares every command beat field by
// field under several display sizes and random stalls on both streams.
// ----------------------------------------------------------------------------
module vt100_escape_cursor_engine_tb;
  import vtec_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_INIT_FG = 2'd2;
  localparam logic [1:0] REG_INIT_BG = 2'd3;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  row;
    logic [7:0]  cs;
    logic [7:0]  ce;
    logic [7:0]  glyph;
    logic [15:0] fg;
    logic [15:0] bg;
    logic        st;
  } vt_cmd_t;

  class cmd_scoreboard;
    vt_cmd_t pending[$];
    int errors;
    int seen;
    logic [6:0] rows_reg;
    logic [7:0] cols_reg;
    logic [15:0] fg_reg, bg_reg;
    logic [1:0] phase, slot;
    int p1, p2;
    bit h1, h2, wrap;
    int crow, ccol, srow, scol;
    logic [15:0] fg, bg;

    function void reset_state();
      phase = 0; slot = 0; p1 = 0; p2 = 0; h1 = 0; h2 = 0;
      crow = 0; ccol = 0; srow = 0; scol = 0; wrap = 0;
      fg = fg_reg; bg = bg_reg;
    endfunction

    function void power_on();
      rows_reg = MAX_ROWS_RST; cols_reg = MAX_COLS_RST;
      fg_reg = FG_RST; bg_reg = BG_RST;
      errors = 0; seen = 0;
      reset_state();
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] v);
      case (idx)
        REG_MAX_ROWS: rows_reg = v[6:0];
        REG_MAX_COLS: cols_reg = v[7:0];
        REG_INIT_FG: fg_reg = v;
        default: bg_reg = v;
      endcase
    endfunction

    function logic [15:0] palette(int i);
      case (i)
        0: return 16'h0000; 1: return 16'hF800; 2: return 16'h07E0; 3: return 16'hFFE0;
        4: return 16'h001F; 5: return 16'hF81F; 6: return 16'h07FF;
        default: return 16'hFFFF;
      endcase
    endfunction

    function bit set_color(int p, bit present);
      if (!present || p < 30 || p > 47) return 0;
      if (p <= 37) fg = palette(p - 30);
      else if (p >= 40) bg = palette(p - 40);
      return 1;
    endfunction

    function void push(int c, int r, int s, int e, int g, bit st);
      vt_cmd_t x;
      x.cmd = 2'(c); x.row = 6'(r); x.cs = 8'(s); x.ce = 8'(e); x.glyph = 8'(g);
      x.fg = fg; x.bg = bg; x.st = st;
      pending.push_back(x);
    endfunction

    function void note_char(logic [7:0] c, bit st);
      int rows, cols, n, q1, q2;
      bit k1, k2;
      rows = (rows_reg == 0) ? 1 : (rows_reg > 64 ? 64 : rows_reg);
      cols = (cols_reg == 0) ? 1 : (cols_reg > 128 ? 128 : cols_reg);
      if (crow >= rows) crow = rows - 1;
      if (ccol >= cols) ccol = cols - 1;
      if (phase == 2) begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          if (slot == 0) begin
            p1 = p1 * 10 + (c - CH_ZERO); if (p1 > 255) p1 = 255; h1 = 1;
          end else if (slot == 1) begin
            p2 = p2 * 10 + (c - CH_ZERO); if (p2 > 255) p2 = 255; h2 = 1;
          end
          return;
        end
        if (c == CH_SEMI) begin
          if (slot < 2) slot++;
          return;
        end
        phase = 0;
        q1 = p1; q2 = p2; k1 = h1; k2 = h2; n = k1 ? q1 : 1;
        slot = 0; p1 = 0; p2 = 0; h1 = 0; h2 = 0;
        case (c)
          "h": if (k1 && q1 == 7) wrap = 1;
          "l": if (k1 && q1 == 7) wrap = 0;
          "H", "f": begin
            if (k1 && q1 < rows) crow = q1;
            if (k2 && q2 < cols) ccol = q2;
            if (!k1 && !k2) begin crow = 0; ccol = 0; end
          end
          "A": crow = (n > crow) ? 0 : crow - n;
          "B": crow = (crow + n >= rows) ? rows - 1 : crow + n;
          "C": ccol = (ccol + n >= cols) ? cols - 1 : ccol + n;
          "D": ccol = (n > ccol) ? 0 : ccol - n;
          "s": begin srow = crow; scol = ccol; end
          "u": begin
            crow = (srow >= rows) ? rows - 1 : srow;
            ccol = (scol >= cols) ? cols - 1 : scol;
          end
          "K": begin
            if (k1 && q1 == 1) push(CMD_ERASE, crow, 0, ccol, CH_SPACE, st);
            else if (k1 && q1 == 2) push(CMD_ERASE, crow, 0, cols, CH_SPACE, st);
            else push(CMD_ERASE, crow, ccol, cols, CH_SPACE, st);
          end
          "J": if (k1 && q1 == 2) begin
            push(CMD_CLEAR, 0, 0, 0, CH_SPACE, st);
            crow = 0; ccol = 0;
          end
          "m": if (set_color(q1, k1)) void'(set_color(q2, k2));
          default: ;
        endcase
        return;
      end
      if (phase == 1) begin
        if (c == CH_LBRK) begin
          phase = 2; slot = 0; p1 = 0; p2 = 0; h1 = 0; h2 = 0;
        end else phase = 0;
        return;
      end
      if (c == CH_ESC) phase = 1;
      else if (c == CH_CR) ccol = 0;
      else if (c == CH_LF) begin
        if (crow + 1 < rows) crow++;
      end else if (c == CH_BS) begin
        if (ccol > 0) ccol--;
      end else begin
        push(CMD_DRAW, crow, ccol, ccol + 1, c, st);
        if (ccol + 1 >= cols) begin
          if (wrap) begin
            ccol = 0;
            if (crow + 1 < rows) crow++;
          end
        end else ccol++;
      end
    endfunction

    function void check_beat(vt_cmd_t got);
      vt_cmd_t x;
      seen++;
      if (pending.size() == 0) begin
        $error("unexpected command beat %h", got);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (got.cmd !== x.cmd) begin $error("command exp %0d got %0d", x.cmd, got.cmd); errors++; end
      if (got.row !== x.row) begin $error("row exp %0d got %0d", x.row, got.row); errors++; end
      if (got.cs !== x.cs) begin $error("col_start exp %0d got %0d", x.cs, got.cs); errors++; end
      if (got.ce !== x.ce) begin $error("col_end exp %0d got %0d", x.ce, got.ce); errors++; end
      if (got.glyph !== x.glyph) begin
        $error("glyph exp %h got %h", x.glyph, got.glyph); errors++;
      end
      if (got.fg !== x.fg) begin $error("fg_color exp %h got %h", x.fg, got.fg); errors++; end
      if (got.bg !== x.bg) begin $error("bg_color exp %h got %h", x.bg, got.bg); errors++; end
      if (got.st !== x.st) begin
        $error("see_through_out exp %0d got %0d", x.st, got.st); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready, s_tuser = 0;
  logic [7:0] s_tdata = 0;
  logic m_tvalid, m_tready = 0, m_tuser;
  logic [63:0] m_tdata;
  logic cfg_we = 0;
  logic [1:0] cfg_index = 0;
  logic [15:0] cfg_wdata = 0;

  cmd_scoreboard sb = new();
  int src_idle = 0, sink_stall = 0;
  bit hold_off = 0;
  int idle_cycles = 0, chars_sent = 0;

  always #4 clk = ~clk;

  vt100_escape_cursor_engine u_top (.*);

  // tdata fields from bit 0: command, row, col_start, col_end, glyph, fg, bg
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_beat({m_tdata[1:0], m_tdata[7:2], m_tdata[15:8], m_tdata[23:16],
                     m_tdata[31:24], m_tdata[47:32], m_tdata[63:48], m_tuser});
    if (!rst)
      m_tready <= !hold_off && ($urandom_range(99) >= sink_stall);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_char(logic [7:0] c, bit st);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1; s_tdata <= c; s_tuser <= st;
    do @(posedge clk); while (!s_tready);
    sb.note_char(c, st);
    chars_sent++;
  endtask

  task automatic send_str(string s);
    foreach (s[i]) send_char(s[i], 1'($urandom_range(1)));
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic send_escape();
    int k;
    string fin = "hlHfABCDsuKJmxz";
    send_char(CH_ESC, 1'($urandom_range(1)));
    if ($urandom_range(19) == 0) begin
      send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
      return;
    end
    send_char(CH_LBRK, 0);
    k = $urandom_range(3);
    if (k > 0) begin
      case ($urandom_range(4))
        0: send_str($sformatf("%0d", $urandom_range(9)));
        1: send_str($sformatf("%0d", $urandom_range(30, 47)));
        2: send_str($sformatf("%0d", $urandom_range(70)));
        3: send_str($sformatf("%0d", $urandom_range(2000)));
        default: send_str("7");
      endcase
    end
    if (k > 1) begin
      send_char(CH_SEMI, 0);
      send_str($sformatf("%0d", (k == 3) ? $urandom_range(47) : $urandom_range(140)));
      if ($urandom_range(5) == 0) send_str(";5");
    end else if ($urandom_range(7) == 0) send_char(CH_SEMI, 0);
    send_char(fin[$urandom_range(fin.len() - 1)], 1'($urandom_range(1)));
  endtask

  task automatic random_run(int count);
    int i, r;
    for (i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 45) send_char(8'($urandom_range(32, 126)), 1'($urandom_range(1)));
      else if (r < 75) send_escape();
      else if (r < 85) begin
        case ($urandom_range(3))
          0: send_char(CH_CR, 0); 1: send_char(CH_LF, 1);
          2: send_char(CH_BS, 0); default: send_char(8'($urandom_range(31)), 1);
        endcase
      end else send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    int ph;
    sb.power_on();
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: draws, controls, each escape, saturation, clamps, colors
    send_char(8'h00, 0); send_char(8'hFF, 1); send_str("A");
    send_char(CH_BS, 1); send_char(CH_CR, 0); send_char(CH_LF, 0);
    send_str("\033[7hZ\033[99;99H\033[5;20f\033[A\033[999B\033[C\033[3D");
    send_str("\033[s\033[HQ\033[u\033[K\033[1K\033[2K\033[2J");
    send_str("\033[31;42m\033[38;47m\033[29;41m\033[m\033[7l\033x\033[1;2;3H\033[q");
    drain();

    write_cfg(REG_MAX_ROWS, 16'd1); write_cfg(REG_MAX_COLS, 16'd1);
    write_cfg(REG_INIT_FG, 16'h1234); write_cfg(REG_INIT_BG, 16'hFFFF);
    random_run(80);
    drain();
    write_cfg(REG_MAX_ROWS, 16'd127); write_cfg(REG_MAX_COLS, 16'd255);
    send_str("\033[7h\033[63;127H");
    random_run(80);
    drain();
    write_cfg(REG_MAX_ROWS, 16'd0); write_cfg(REG_MAX_COLS, 16'd0);
    random_run(50);
    drain();
    write_cfg(REG_MAX_ROWS, 16'd64); write_cfg(REG_MAX_COLS, 16'd128);
    write_cfg(REG_INIT_FG, 16'h0000); write_cfg(REG_INIT_BG, 16'h5A5A);

    for (ph = 0; ph < 4; ph++) begin
      src_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 60 : 32) : 0;
      sink_stall = (ph == 2) ? 60 : ((ph == 3) ? 32 : 0);
      random_run(90);
      drain();
      write_cfg(REG_MAX_ROWS, 16'($urandom_range(1, 64)));
      write_cfg(REG_MAX_COLS, 16'($urandom_range(1, 128)));
    end

    // long output hold-off so the queue fills and the input stalls
    src_idle = 0; sink_stall = 0;
    fork
      begin hold_off = 1; repeat (300) @(posedge clk); hold_off = 0; end
      random_run(60);
    join
    drain();
    write_cfg(REG_MAX_ROWS, 16'd8); write_cfg(REG_MAX_COLS, 16'd10);
    src_idle = 20; sink_stall = 20;
    random_run(120);
    drain();

    $display("Sent %0d characters, checked %0d command beats over several display sizes.",
             chars_sent, sb.seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
